[hw/rtl/icc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icc_pkg
// Shared widths, fixed-point constants and types of the colormap core.
// ----------------------------------------------------------------------------
package icc_pkg;

   localparam int ITER_FRACTION_BITS = 8;
   localparam int ANGLE_BITS         = 12;

   localparam int ITER_W  = 24;
   localparam int LIMIT_W = 16;
   localparam int DIV_W   = LIMIT_W + ITER_FRACTION_BITS;
   // remainder width: room for the doubled partial remainder
   localparam int REM_W   = ((DIV_W > ITER_W) ? DIV_W : ITER_W) + 1;

   localparam int QUOT_W     = 32;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = QUOT_W / DIV_STEPS;

   localparam int X_SHIFT = 17 - ANGLE_BITS;

   localparam logic [31:0] BLACK_RGBA = 32'h0000_00FF;

   localparam logic [31:0] K_T10     = 32'd26701769;
   localparam logic [31:0] K_T15     = 32'd40052653;
   localparam logic [31:0] K_T5      = 32'd13350884;
   localparam logic [31:0] K_T7      = 32'd18691238;
   localparam logic [31:0] K_T11     = 32'd29371945;
   localparam logic [31:0] K_TIME03  = 32'd801053;
   localparam logic [31:0] K_TIME05  = 32'd1335088;
   localparam logic [31:0] K_TIME015 = 32'd400527;
   localparam logic [31:0] K_TIME01  = 32'd267018;
   localparam logic [31:0] K_TIME035 = 32'd934562;
   localparam logic [31:0] K_TIME025 = 32'd667544;
   localparam logic [31:0] OFS_2094  = 32'd1431385687;
   localparam logic [31:0] OFS_4188  = 32'd2862771374;
   localparam logic signed [31:0] HALF_RAD_PER_Q15 = 32'sd10430;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam logic [1:0] MODE_GRAY    = 2'd0;
   localparam logic [1:0] MODE_ANIM    = 2'd1;
   localparam logic [1:0] MODE_PALETTE = 2'd2;

   localparam logic [1:0] REG_COLOR_MODE = 2'd0;
   localparam logic [1:0] REG_MAX_ITER   = 2'd1;
   localparam logic [1:0] REG_FRAME_TIME = 2'd2;

   typedef logic signed [16:0] q15_type;

endpackage
`default_nettype wire

[hw/rtl/icc_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icc_divider
// Pipelined restoring divider: quotient = floor(iter * 2^32 / divisor),
// valid for iter < divisor, four quotient bits per stage.
// ----------------------------------------------------------------------------
module icc_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic                         in_black,
   input  wire logic [icc_pkg::ITER_W-1:0]   in_iter,
   input  wire logic [icc_pkg::DIV_W-1:0]    divisor,
   output logic                              out_valid,
   output logic                              out_black,
   output logic [icc_pkg::QUOT_W-1:0]        out_quot
);
   import icc_pkg::*;

   logic [REM_W-1:0]  rem_ff   [DIV_STAGES];
   logic [REM_W-1:0]  rem_in   [DIV_STAGES];
   logic [QUOT_W-1:0] quot_ff  [DIV_STAGES];
   logic [QUOT_W-1:0] quot_in  [DIV_STAGES];
   logic              valid_ff [DIV_STAGES];
   logic              black_ff [DIV_STAGES];

   always_comb begin
      logic [REM_W-1:0]  r;
      logic [QUOT_W-1:0] q;
      for (int st = 0; st < DIV_STAGES; st++) begin
         if (st == 0) begin
            r = REM_W'(in_iter);
            q = '0;
         end else begin
            r = rem_ff[st-1];
            q = quot_ff[st-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            r = {r[REM_W-2:0], 1'b0};
            q = {q[QUOT_W-2:0], 1'b0};
            if (r >= REM_W'(divisor)) begin
               r = r - REM_W'(divisor);
               q[0] = 1'b1;
            end
         end
         rem_in[st]  = r;
         quot_in[st] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int st = 0; st < DIV_STAGES; st++) valid_ff[st] <= 1'b0;
      end else if (en) begin
         for (int st = 0; st < DIV_STAGES; st++)
            valid_ff[st] <= (st == 0) ? in_valid : valid_ff[st-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int st = 0; st < DIV_STAGES; st++) begin
            rem_ff[st]   <= rem_in[st];
            quot_ff[st]  <= quot_in[st];
            black_ff[st] <= (st == 0) ? in_black : black_ff[st-1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_black = black_ff[DIV_STAGES-1];
   assign out_quot  = quot_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

[hw/rtl/icc_sine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icc_sine
// Four-stage Q1.15 sine of a binary-turn angle, quarter-wave polynomial
// mirrored and negated per quadrant.
// ----------------------------------------------------------------------------
module icc_sine (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [31:0]      angle,
   output icc_pkg::q15_type      sine
);
   import icc_pkg::*;

   logic [ANGLE_BITS-1:0] idx;
   logic [15:0] x_low, x_in, x2_in;
   logic [31:0] sq;
   logic [15:0] x1_ff, x2_ff, x2b_ff, x3_ff, x4_ff, p_ff, p2_ff, p_in, p2_in, y;
   logic        neg1_ff, neg2_ff, neg3_ff;
   q15_type     sine_ff, sine_in;

   always_comb begin
      idx   = angle[31 -: ANGLE_BITS];
      x_low = 16'(idx[ANGLE_BITS-3:0]) << X_SHIFT;
      x_in  = idx[ANGLE_BITS-2] ? (16'd32768 - x_low) : x_low;
      sq    = 32'(x_in) * 32'(x_in);
      x2_in = 16'(sq >> 15);
      p_in  = 16'd21024 - 16'((32'(x2_ff) * 32'd2320) >> 15);
      p2_in = 16'd51472 - 16'((32'(p_ff) * 32'(x2b_ff)) >> 15);
      y     = 16'((32'(p2_ff) * 32'(x4_ff)) >> 15);
      sine_in = neg3_ff ? -q15_type'({1'b0, y}) : q15_type'({1'b0, y});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff   <= x_in;
         x2_ff   <= x2_in;
         neg1_ff <= idx[ANGLE_BITS-1];
         // stage 2
         x2b_ff  <= x2_ff;
         p_ff    <= p_in;
         x3_ff   <= x1_ff;
         neg2_ff <= neg1_ff;
         // stage 3
         p2_ff   <= p2_in;
         neg3_ff <= neg2_ff;
         // stage 4
         sine_ff <= sine_in;
      end
   end

   // x is carried through x3 and x4 so that it lines up with p2 for stage 4
   always_ff @(posedge clock) begin
      if (en) x4_ff <= x3_ff;
   end

   assign sine = sine_ff;

endmodule
`default_nettype wire

[hw/rtl/icc_skid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icc_skid
// Two-word output buffer between the pipeline and the result channel.
// ----------------------------------------------------------------------------
module icc_skid (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic [31:0] push_data,
   output logic             space,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [31:0]      out_data
);
   logic [31:0] mem_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  count_ff;
   logic        pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = mem_ff[rptr_ff];
   assign space     = count_ff != 2'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

[hw/rtl/iteration_count_colormap_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iteration_count_colormap_core
// Maps a smoothed escape-iteration count per pixel to an RGBA word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one Q16.8 count per word, rsp_* one packed RGBA word
//   (red 31:24, green 23:16, blue 15:8, alpha 0xFF). csr_* is an APB-style
//   port: color_mode at 0x0, max_iterations at 0x4, frame_time at 0x8.
//   One pixel is taken per clock while the output buffer has room. From
//   acceptance to rsp_tvalid a pixel passes eight divider stages (four
//   quotient bits each), one angle multiply, one angle sum, four sine stages,
//   one level/gain stage and the output buffer. The frame-time phases come
//   from a free-running side pipeline that settles after a register write
//   ahead of any pixel accepted after the write reaching the angle sum.
//   When the receiver stalls, the two-word output buffer absorbs results;
//   once it is full the whole pipeline holds and req_tready drops, so no
//   word is lost or repeated. Reset (synchronous) empties the pipeline and
//   loads color_mode 0, max_iterations 64, frame_time 0.
// ----------------------------------------------------------------------------
module iteration_count_colormap_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // iter_count[23:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // pixel_rgba[31:0]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import icc_pkg::*;

   localparam int SINE_LAT = 4;

   // configuration
   logic [1:0]  color_mode_ff;
   logic [15:0] max_iter_ff;
   logic [31:0] frame_time_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_GRAY;
         max_iter_ff   <= 16'd64;
         frame_time_ff <= 32'd0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_COLOR_MODE: color_mode_ff <= csr_pwdata[1:0];
            REG_MAX_ITER:   max_iter_ff   <= csr_pwdata[15:0];
            REG_FRAME_TIME: frame_time_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_COLOR_MODE: csr_prdata = {30'd0, color_mode_ff};
         REG_MAX_ITER:   csr_prdata = {16'd0, max_iter_ff};
         REG_FRAME_TIME: csr_prdata = frame_time_ff;
         default:        csr_prdata = 32'd0;
      endcase
   end

   // frame-time phases, free running
   logic [31:0] tp_ff, t03_ff, t015_ff, t01_ff, t035_ff, t025_ff;
   logic [31:0] offg_ff, offb_ff;
   q15_type     s015, c01;

   function automatic logic [31:0] time_ang(input logic [31:0] ft, input logic [31:0] k);
      logic [63:0] prod;
      prod = 64'(ft) * 64'(k);
      return prod[39:8];
   endfunction

   always_ff @(posedge clock) begin
      tp_ff   <= time_ang(frame_time_ff, K_TIME05);
      t03_ff  <= time_ang(frame_time_ff, K_TIME03);
      t015_ff <= time_ang(frame_time_ff, K_TIME015);
      t01_ff  <= time_ang(frame_time_ff, K_TIME01);
      t035_ff <= time_ang(frame_time_ff, K_TIME035);
      t025_ff <= time_ang(frame_time_ff, K_TIME025);
      offg_ff <= 32'(32'(s015) * HALF_RAD_PER_Q15);
      offb_ff <= 32'(32'(c01) * HALF_RAD_PER_Q15);
   end

   icc_sine u_sin015 (.clock(clock), .en(1'b1), .angle(t015_ff), .sine(s015));
   icc_sine u_cos01  (.clock(clock), .en(1'b1), .angle(t01_ff + QUARTER_TURN), .sine(c01));

   // pipeline control: every pixel stage moves while the output buffer has room
   logic en, buf_space;
   assign en         = buf_space;
   assign req_tready = en;

   logic [DIV_W-1:0] divisor;
   logic             in_black;
   assign divisor  = {max_iter_ff, ITER_FRACTION_BITS'(0)};
   assign in_black = REM_W'(req_tdata) >= REM_W'(divisor);

   logic        dv, dblk;
   logic [31:0] dq;

   icc_divider u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_tvalid), .in_black(in_black), .in_iter(req_tdata),
      .divisor(divisor),
      .out_valid(dv), .out_black(dblk), .out_quot(dq)
   );

   // stage a: t-angle products
   function automatic logic [31:0] t_ang(input logic [31:0] tq, input logic [31:0] k);
      logic [63:0] prod;
      prod = 64'(tq) * 64'(k);
      return prod[55:24];
   endfunction

   logic        va_ff, blka_ff;
   logic [31:0] a10_ff, a15_ff, a5_ff, a7_ff, a11_ff;

   // stage b: phase sums
   logic        vb_ff, blkb_ff;
   logic [31:0] ang_ff [6];
   logic [31:0] ang_in [6];
   logic [31:0] ph, gray;

   always_comb begin
      ph   = a15_ff + tp_ff;
      gray = a10_ff + QUARTER_TURN + ((color_mode_ff == MODE_ANIM) ? t03_ff : 32'd0);
      ang_in[0] = (color_mode_ff == MODE_PALETTE) ? ph : gray;
      ang_in[1] = ph + OFS_2094 + offg_ff;
      ang_in[2] = ph + OFS_4188 + offb_ff;
      ang_in[3] = a5_ff + tp_ff;
      ang_in[4] = a7_ff + t035_ff + QUARTER_TURN;
      ang_in[5] = a11_ff + t025_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= dv;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         blka_ff <= dblk;
         a10_ff  <= t_ang(dq, K_T10);
         a15_ff  <= t_ang(dq, K_T15);
         a5_ff   <= t_ang(dq, K_T5);
         a7_ff   <= t_ang(dq, K_T7);
         a11_ff  <= t_ang(dq, K_T11);
         blkb_ff <= blka_ff;
         for (int i = 0; i < 6; i++) ang_ff[i] <= ang_in[i];
      end
   end

   // sine lanes
   q15_type sn [6];
   logic    vs_ff   [SINE_LAT];
   logic    blks_ff [SINE_LAT];

   for (genvar i = 0; i < 6; i++) begin : g_lane
      icc_sine u_sine (.clock(clock), .en(en), .angle(ang_ff[i]), .sine(sn[i]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SINE_LAT; i++) vs_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < SINE_LAT; i++) vs_ff[i] <= (i == 0) ? vb_ff : vs_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SINE_LAT; i++) blks_ff[i] <= (i == 0) ? blkb_ff : blks_ff[i-1];
      end
   end

   // stage c: levels and gains
   function automatic logic [7:0] level(input q15_type s);
      logic [16:0] u;
      logic [24:0] prod;
      u    = 17'(s + q15_type'(32768));
      prod = 25'(u) * 25'd255;
      return prod[23:16];
   endfunction

   function automatic logic [15:0] gain(input q15_type s);
      logic [16:0] u;
      logic [31:0] prod;
      u    = 17'(s + q15_type'(32768));
      prod = 32'(u) * 32'd6554;
      return 16'(prod >> 15) + 16'd19660;
   endfunction

   function automatic logic [7:0] gained(input logic [7:0] c, input logic [15:0] g);
      logic [23:0] prod;
      prod = 24'(c) * 24'(g);
      return (prod[23:15] > 9'd255) ? 8'd255 : prod[22:15];
   endfunction

   logic        vc_ff, blkc_ff;
   logic [7:0]  lvl_ff [3];
   logic [15:0] gn_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (en) vc_ff <= vs_ff[SINE_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         blkc_ff <= blks_ff[SINE_LAT-1];
         for (int i = 0; i < 3; i++) begin
            lvl_ff[i] <= level(sn[i]);
            gn_ff[i]  <= gain(sn[i+3]);
         end
      end
   end

   logic [31:0] pixel;
   always_comb begin
      if (blkc_ff)
         pixel = BLACK_RGBA;
      else if (color_mode_ff == MODE_PALETTE)
         pixel = {gained(lvl_ff[0], gn_ff[0]), gained(lvl_ff[1], gn_ff[1]),
                  gained(lvl_ff[2], gn_ff[2]), 8'hFF};
      else
         pixel = {lvl_ff[0], lvl_ff[0], lvl_ff[0], 8'hFF};
   end

   icc_skid u_skid (
      .clock(clock), .reset(reset),
      .push(en && vc_ff), .push_data(pixel), .space(buf_space),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );

   // checks
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] == 8'hFF)
      else $error("alpha byte not opaque");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result present right after reset");

endmodule
`default_nettype wire
